// ----- sv/ksel_pkg.sv -----
// ----------------------------------------------------------------------------
// ksel_pkg
// Shared constants and types of the rank selection block.
// ----------------------------------------------------------------------------
package ksel_pkg;

	localparam int MAX_ELEMENTS = 128;
	localparam int DATA_W       = 32;
	localparam int RANK_W       = 8;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W        = (CNT_W > RANK_W) ? CNT_W : RANK_W;
	localparam int BIT_W        = $clog2(DATA_W);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W       = 3;
	localparam int PDATA_W      = 32;

	// Register index as decoded from paddr
	localparam logic REG_RANK = 1'b0;

	// Flip of the sign bit maps two's complement order onto unsigned order
	localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	typedef struct packed {
		logic             scanning;
		logic [CNT_W-1:0] count;
	} back_stat_t;

endpackage

// ----- sv/ksel_front.sv -----
// ----------------------------------------------------------------------------
// ksel_front
// Input side: takes items in and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module ksel_front import ksel_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  item_t       push_item,
	input  logic        pop,
	output item_t       pop_item,
	output queue_stat_t stat
);

	item_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_item   = slots_q[rd_ptr_q];

	// Store an incoming transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- sv/ksel_back.sv -----
// ----------------------------------------------------------------------------
// ksel_back
// Element store and radix selection: one key bit per pass over the store.
// ----------------------------------------------------------------------------
module ksel_back import ksel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RANK_W-1:0] rank,
	input  queue_stat_t       qstat,
	input  item_t             item,
	output logic              pop,
	output logic              done,
	output logic [DATA_W-1:0] kth_value,
	output logic              out_of_range,
	output back_stat_t        stat
);

	typedef enum logic {ST_LOAD, ST_SCAN} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] mem [MAX_ELEMENTS];
	logic [DATA_W-1:0] rdata_q;
	logic              rvalid_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  c_q;
	logic [CNT_W-1:0]  j_q;
	logic [BIT_W-1:0]  bit_q;
	logic [DATA_W-1:0] prefix_q;
	logic [DATA_W-1:0] himask_q;
	logic              done_q;
	logic [DATA_W-1:0] result_q;
	logic              oor_q;

	logic              we;
	logic [CNT_W-1:0]  count_next;
	logic [CMP_W-1:0]  rank_c;
	logic              bad;
	logic              rd_en;
	logic [DATA_W-1:0] key;
	logic              hit;
	logic [CNT_W-1:0]  c_tot;
	logic              pass_end;
	logic [DATA_W-1:0] bit_mask;
	logic              take_one;
	logic [DATA_W-1:0] prefix_next;

	assign pop        = (state_q == ST_LOAD) && !qstat.empty;
	assign we         = pop && (count_q < CNT_W'(MAX_ELEMENTS));
	assign count_next = count_q + CNT_W'(we);
	assign rank_c     = CMP_W'(rank);
	assign bad        = (rank_c == '0) || (rank_c > CMP_W'(count_next));

	// Scan: count keys that match the prefix and hold zero at the current bit
	assign rd_en       = (state_q == ST_SCAN) && (j_q < n_q);
	assign key         = rdata_q ^ SIGN_FLIP;
	assign hit         = rvalid_q && (((key ^ prefix_q) & himask_q) == '0) && !key[bit_q];
	assign c_tot       = c_q + CNT_W'(hit);
	assign pass_end    = (state_q == ST_SCAN) && (j_q == n_q);
	assign bit_mask    = DATA_W'(1) << bit_q;
	assign take_one    = (k_q > c_tot);
	assign prefix_next = take_one ? (prefix_q | bit_mask) : prefix_q;

	// Element store with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[count_q[IDX_W-1:0]] <= item.value;
		end
		rdata_q <= mem[j_q[IDX_W-1:0]];
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && item.last && bad) begin
			result_q <= '0;
			oor_q    <= 1'b1;
		end else if (pass_end && (bit_q == '0)) begin
			result_q <= prefix_next ^ SIGN_FLIP;
			oor_q    <= 1'b0;
		end
	end

	// Sequencer: load, then one pass per key bit from the top down, or an out-of-range answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			n_q      <= '0;
			k_q      <= '0;
			c_q      <= '0;
			j_q      <= '0;
			bit_q    <= '0;
			prefix_q <= '0;
			himask_q <= '0;
			rvalid_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			rvalid_q <= rd_en;
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (!item.last) begin
							count_q <= count_next;
						end else if (bad) begin
							count_q <= '0;
							done_q  <= 1'b1;
						end else begin
							count_q  <= count_next;
							n_q      <= count_next;
							k_q      <= CNT_W'(rank_c);
							c_q      <= '0;
							j_q      <= '0;
							bit_q    <= BIT_W'(DATA_W - 1);
							prefix_q <= '0;
							himask_q <= '0;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (pass_end) begin
						prefix_q <= prefix_next;
						himask_q <= himask_q | bit_mask;
						if (take_one) begin
							k_q <= k_q - c_tot;
						end
						c_q <= '0;
						j_q <= '0;
						if (bit_q == '0) begin
							count_q <= '0;
							done_q  <= 1'b1;
							state_q <= ST_LOAD;
						end else begin
							bit_q <= bit_q - 1'b1;
						end
					end else begin
						c_q <= c_tot;
						j_q <= j_q + 1'b1;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign done           = done_q;
	assign kth_value      = result_q;
	assign out_of_range   = oor_q;
	assign stat.scanning  = (state_q == ST_SCAN);
	assign stat.count     = count_q;

endmodule

// ----- sv/kth_smallest_select.sv -----
// ----------------------------------------------------------------------------
// kth_smallest_select
// Loads a set of signed values and returns the value of a programmed rank.
// ----------------------------------------------------------------------------
// Input: drive value and last with start; the transfer happens on a rising
// edge where start is high and busy is low. Items enter a four-deep queue,
// so one item per cycle is taken until the queue fills. The item with last
// high is part of the set and closes it.
// Output: one result per set, shown for one cycle with done high. The
// receiver cannot stall, so no holding is needed. out_of_range is set and
// kth_value is zero when rank is zero or above the number of held values.
// Timing: the back end stores one value per cycle while loading; it pops
// none during selection, which after the closing value makes one pass over
// the store per key bit, bounded by the single read port of the element
// store. An out-of-range request answers in the cycle after the closing
// value leaves the queue. Up to 128 values are held; more are dropped.
// Configuration: rank at byte address 0 over the APB port, reset value 1;
// write it only while the block is idle. Reset empties queue and set.
// ----------------------------------------------------------------------------
module kth_smallest_select import ksel_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  value,
	input  logic                last,
	output logic                done,
	output logic signed [31:0]  kth_value,
	output logic                out_of_range,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	logic [RANK_W-1:0] rank_q;
	item_t             push_item;
	item_t             pop_item;
	queue_stat_t       qstat;
	back_stat_t        bstat;
	logic              pop;
	logic [DATA_W-1:0] result;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_W'(1);
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RANK)) begin
			rank_q <= pwdata[RANK_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_RANK) ? PDATA_W'(rank_q) : '0;

	// Front end: queue the incoming transfer
	assign busy            = qstat.full;
	assign push_item.value = value;
	assign push_item.last  = last;

	ksel_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (qstat)
	);

	ksel_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rank         (rank_q),
		.qstat        (qstat),
		.item         (pop_item),
		.pop          (pop),
		.done         (done),
		.kth_value    (result),
		.out_of_range (out_of_range),
		.stat         (bstat)
	);

	assign kth_value = result;

	// Checks
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (kth_value == '0))
		else $error("out-of-range result carries a nonzero value");

	a_no_result_mid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !bstat.scanning)
		else $error("result strobe while selection still runs");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.count <= CNT_W'(MAX_ELEMENTS))
		else $error("element count above store depth");

	a_scan_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.scanning |-> !pop)
		else $error("queue popped during selection");

endmodule
